// ===== rtl/core/sorted_array_binary_search_core_assert.svh =====
// assertion macros used by the checker in sabs_checker.sv
`ifndef SORTED_ARRAY_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_ARRAY_BINARY_SEARCH_CORE_ASSERT_SVH

// clocked check, switched off while reset is held
`define SABS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds across reset
`define SABS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/sabs_pkg.sv =====
package sabs_pkg;

  // fixed field widths of the stream payloads
  localparam int POS_W      = 10;
  localparam int OPERAND_W  = 32;
  localparam int HBOUND_W   = 11;
  localparam int RANGE_W    = 12;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  // tdata bit positions of the input transaction
  localparam int IDX_LSB = 0;
  localparam int OPD_LSB = IDX_LSB + POS_W;
  localparam int LOW_LSB = OPD_LSB + OPERAND_W;
  localparam int HIB_LSB = LOW_LSB + POS_W;

  localparam int DEFAULT_STORE_DEPTH = 1024;
  localparam int DEFAULT_VALUE_WIDTH = 32;

  // command carried on in_tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

endpackage

// ===== rtl/core/sorted_array_binary_search_core.sv =====
// sorted store binary search core
//
// input channel in_*: in_tuser selects the command. a load transaction writes
// one signed word into the store and gives no result (indexes beyond the
// store are dropped). a search transaction carries a key and an inclusive
// range [low, high]; high below low means an empty range, high beyond the
// store is clipped to the last entry. the store is expected to be sorted
// ascending over the searched range, and only written entries may be probed.
// output channel out_*: one transaction per search, found on out_tuser and
// the matching position on out_tdata (zero when not found).
// a load leaves the block idle and ready again at once. a search of p probes
// passes p times through PROBE then COMPARE; a miss ends in one more PROBE
// (an empty range only in that PROBE): each PROBE is the midpoint add and store
// read, each COMPARE uses the shared comparator. for 1024 entries p is at most 11.
// in_tready is low from search acceptance until the result is taken; while
// the receiver stalls, the result register holds and nothing new is taken.
// reset clears the sequencer and the output valid; store contents are kept
// and are undefined until written.
module sorted_array_binary_search_core #(
  parameter int STORE_DEPTH = sabs_pkg::DEFAULT_STORE_DEPTH,
  parameter int VALUE_WIDTH = sabs_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // entry_index[9:0], operand_value[41:10], low_bound[51:42],
  // high_bound[62:52], zero pad[63]
  input  logic [sabs_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // position[9:0], zero pad[15:10]
  output logic [sabs_pkg::OUT_DATA_W-1:0] out_tdata,
  // found[0]
  output logic                             out_tuser
);

  import sabs_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_DONE
  } state_t;

  state_t state_r;

  // unpacked input fields
  logic        [POS_W-1:0]     entry_index;
  logic signed [OPERAND_W-1:0] operand_value;
  logic        [POS_W-1:0]     low_bound;
  logic signed [HBOUND_W-1:0]  high_bound;

  assign entry_index   = in_tdata[IDX_LSB +: POS_W];
  assign operand_value = in_tdata[OPD_LSB +: OPERAND_W];
  assign low_bound     = in_tdata[LOW_LSB +: POS_W];
  assign high_bound    = in_tdata[HIB_LSB +: HBOUND_W];

  // store and its registered read port
  logic signed [VALUE_WIDTH-1:0] store_mem [STORE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_data_r;
  logic        [AW-1:0]          rd_addr;
  logic                          store_we;

  // search working registers
  logic signed [VALUE_WIDTH-1:0] key_r;
  logic signed [RANGE_W-1:0]     low_r;
  logic signed [RANGE_W-1:0]     high_r;
  logic        [POS_W-1:0]       mid_r;

  logic                          out_valid_r;
  logic                          found_r;
  logic        [POS_W-1:0]       pos_r;

  // midpoint path: the shared adder of each probe
  logic signed [RANGE_W-1:0]     span;
  logic signed [RANGE_W-1:0]     mid_sum;
  logic        [POS_W-1:0]       mid_c;
  logic                          range_ok;

  // high bound clipped to the last entry
  int                            hb_int;
  logic signed [RANGE_W-1:0]     high_clip;

  // shared comparator
  logic                          word_eq;
  logic                          word_lt;

  assign in_tready = (state_r == ST_IDLE);

  assign store_we = in_tvalid && in_tready && (in_tuser == CMD_LOAD) &&
                    (32'(entry_index) < STORE_DEPTH);

  always_comb begin
    hb_int = int'(high_bound);
    if (hb_int > STORE_DEPTH - 1) begin
      hb_int = STORE_DEPTH - 1;
    end
    high_clip = RANGE_W'(hb_int);
  end

  assign span     = high_r - low_r;
  assign mid_sum  = low_r + (span >>> 1);
  assign mid_c    = mid_sum[POS_W-1:0];
  assign range_ok = (low_r <= high_r);
  assign rd_addr  = AW'(mid_c);

  assign word_eq = (rd_data_r == key_r);
  assign word_lt = (rd_data_r < key_r);

  // store: one write port for loads, one read port for probes
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[AW'(entry_index)] <= VALUE_WIDTH'(operand_value);
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // search sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      low_r       <= '0;
      high_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid && (in_tuser == CMD_SEARCH)) begin
            key_r   <= VALUE_WIDTH'(operand_value);
            low_r   <= RANGE_W'(low_bound);
            high_r  <= high_clip;
            state_r <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (range_ok) begin
            // read of store_mem[mid] is in flight this cycle
            mid_r   <= mid_c;
            state_r <= ST_COMPARE;
          end else begin
            found_r     <= 1'b0;
            pos_r       <= '0;
            out_valid_r <= 1'b1;
            state_r     <= ST_DONE;
          end
        end
        ST_COMPARE: begin
          if (word_eq) begin
            found_r     <= 1'b1;
            pos_r       <= mid_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_DONE;
          end else if (word_lt) begin
            low_r   <= RANGE_W'(mid_r) + RANGE_W'(1);
            state_r <= ST_PROBE;
          end else begin
            high_r  <= RANGE_W'(mid_r) - RANGE_W'(1);
            state_r <= ST_PROBE;
          end
        end
        ST_DONE: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = found_r;
  assign out_tdata  = OUT_DATA_W'(pos_r);

endmodule

// ===== rtl/core/sabs_checker.sv =====
`include "sorted_array_binary_search_core_assert.svh"

module sabs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sabs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  import sabs_pkg::*;

  // a stalled result keeps its payload
  `SABS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // a miss always reports position zero
  `SABS_ASSERT(a_miss_pos_zero, out_tvalid && !out_tuser |-> out_tdata == '0, "miss with nonzero position")

  // no new transaction is taken while a search is open or its result waits
  `SABS_ASSERT(a_busy_search, in_tvalid && in_tready && in_tuser == CMD_SEARCH |=> !in_tready, "ready after search accept")

  `SABS_ASSERT(a_result_blocks_input, out_tvalid |-> !in_tready, "input taken while result pending")

  // reset clears any pending result
  `SABS_ASSERT_RST(a_reset_clears, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind sorted_array_binary_search_core sabs_checker u_sabs_checker (.*);

// ===== test/sorted_array_binary_search_core_tb.sv =====
module sorted_array_binary_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sabs_pkg::*;

  localparam int STORE_DEPTH  = DEFAULT_STORE_DEPTH;
  localparam int LAST_ENTRY   = STORE_DEPTH - 1;
  localparam int CYCLE_LIMIT  = 800_000;
  // longest search is 11 probes, each a probe and a compare state, plus the output register
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLDOFF_LEN  = 300;

  localparam logic signed [OPERAND_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [OPERAND_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // one search outcome as it leaves the block
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_result_t;

  // mirror of the store plus the queue of search outcomes still owed
  class search_scoreboard;
    logic signed [OPERAND_W-1:0] store [STORE_DEPTH];
    int probe_low;
    int probe_high;
    search_result_t pending_q[$];
    int mismatches;

    function new();
      probe_low  = 0;
      probe_high = 0;
      mismatches = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    // called once per accepted input transaction
    function void note_input(logic cmd, logic [POS_W-1:0] idx,
                             logic signed [OPERAND_W-1:0] val,
                             logic [POS_W-1:0] lo, logic signed [HBOUND_W-1:0] hi);
      int l;
      int h;
      int mid;
      search_result_t res;
      if (cmd == CMD_LOAD) begin
        if (int'(idx) < STORE_DEPTH) store[idx] = val;
        return;
      end
      l = int'(lo);
      h = int'(hi);
      if (h > LAST_ENTRY) h = LAST_ENTRY;
      res = '0;
      while (l <= h) begin
        mid = l + (h - l) / 2;
        probe_low  = l;
        probe_high = h;
        if (store[mid] == val) begin
          res.found    = 1'b1;
          res.position = mid[POS_W-1:0];
          break;
        end
        if (store[mid] < val) l = mid + 1;
        else h = mid - 1;
      end
      if (!res.found) begin
        probe_low  = l;
        probe_high = h;
      end
      pending_q.push_back(res);
    endfunction

    // called once per accepted result transaction
    function void check_result(logic found, logic [POS_W-1:0] position);
      search_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no search outstanding: found %0b position %0d",
                   $realtime, found, position);
        return;
      end
      want = pending_q.pop_front();
      if (found !== want.found || position !== want.position) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: search result mismatch: expected found %0b position %0d, got found %0b position %0d",
                   $realtime, want.found, want.position, found, position);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  search_scoreboard sb;

  // idling knobs, changed between phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off, counted down by the receiver process
  int holdoff_left   = 0;
  int items_sent     = 0;
  int cycle_count    = 0;

  sorted_array_binary_search_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // run guard: a hang anywhere ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_array_binary_search_core verification failed");
      $finish;
    end
  end

  // receiver: random stalls, or a solid hold-off while one is requested
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[POS_W-1:0]);
  end

  // offer one input transaction from a falling edge, return at the falling
  // edge after it was accepted; valid stays high into the next item
  task automatic send_item(logic cmd, logic [POS_W-1:0] idx,
                           logic signed [OPERAND_W-1:0] val,
                           logic [POS_W-1:0] lo, logic signed [HBOUND_W-1:0] hi);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[IDX_LSB +: POS_W]     = idx;
    word[OPD_LSB +: OPERAND_W] = val;
    word[LOW_LSB +: POS_W]     = lo;
    word[HIB_LSB +: HBOUND_W]  = hi;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, idx, val, lo, hi);
    items_sent++;
    @(negedge clk);
  endtask

  // loads carry random bits in the unused bound fields
  task automatic send_load(int idx, logic signed [OPERAND_W-1:0] val);
    send_item(CMD_LOAD, idx[POS_W-1:0], val, POS_W'($urandom), HBOUND_W'($urandom));
  endtask

  // searches carry random bits in the unused index field
  task automatic send_search(logic signed [OPERAND_W-1:0] key, int lo, int hi);
    send_item(CMD_SEARCH, POS_W'($urandom), key, lo[POS_W-1:0], hi[HBOUND_W-1:0]);
  endtask

  // sender pause: nothing offered until every outcome has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  // one search over a fully written store with a mix of ranges and keys
  task automatic random_search();
    int r;
    int lo;
    int hi;
    int pick;
    logic signed [OPERAND_W-1:0] key;
    r = $urandom_range(99);
    if (r < 50) begin
      lo = 0;
      hi = LAST_ENTRY;
    end else if (r < 80) begin
      lo = $urandom_range(LAST_ENTRY);
      hi = $urandom_range(LAST_ENTRY, lo);
    end else if (r < 92) begin
      // empty range, down to a high bound of minus one
      lo = $urandom_range(LAST_ENTRY);
      hi = int'($urandom_range(lo)) - 1;
    end else begin
      lo = $urandom_range(LAST_ENTRY);
      hi = lo;
    end
    pick = (hi >= lo) ? int'($urandom_range(hi, lo)) : lo;
    r = $urandom_range(99);
    if (r < 45) key = sb.store[pick];
    else if (r < 70) key = sb.store[pick] + int'($urandom_range(6)) - 3;
    else if (r < 85) key = $urandom;
    else begin
      case ($urandom_range(3))
        0: key = VAL_MIN;
        1: key = VAL_MAX;
        2: key = -1;
        default: key = '0;
      endcase
    end
    send_search(key, lo, hi);
  endtask

  // mostly searches, with short sorted rewrites and some unsorted noise loads
  task automatic random_phase(int n_items);
    int stop;
    int r;
    int a;
    int b;
    longint lower;
    longint upper;
    longint step;
    longint v;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      if (r < 12) begin
        // rewrite a short region, staying between its neighbours
        a = $urandom_range(LAST_ENTRY);
        b = a + int'($urandom_range(11));
        if (b > LAST_ENTRY) b = LAST_ENTRY;
        lower = (a > 0) ? longint'(sb.store[a-1]) : longint'(VAL_MIN);
        upper = (b < LAST_ENTRY) ? longint'(sb.store[b+1]) : longint'(VAL_MAX);
        if (upper < lower) upper = lower;
        step = (upper - lower) / (b - a + 1);
        for (int i = a; i <= b; i++) begin
          v = lower + step * (i - a) + (longint'($urandom) % (step + 1));
          send_load(i, v[OPERAND_W-1:0]);
        end
      end else if (r < 16) begin
        send_load($urandom_range(LAST_ENTRY), $urandom);
      end else begin
        random_search();
      end
    end
  endtask

  initial begin
    longint base;
    longint v;
    logic signed [OPERAND_W-1:0] prev;
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: a small sorted run with duplicates and both extremes
    send_load(0, VAL_MIN);
    send_load(1, -5);
    send_load(2, 0);
    send_load(3, 7);
    send_load(4, 7);
    send_load(5, 100);
    send_load(6, VAL_MAX);
    send_load(LAST_ENTRY, VAL_MAX);
    send_search(VAL_MIN, 0, 6);
    send_search(VAL_MAX, 0, 6);
    send_search(0, 0, 6);
    send_search(7, 0, 6);
    // keys that fall in gaps inside the run
    send_search(50, 0, 6);
    send_search(-6, 0, 6);
    // empty ranges: high bound of minus one, and high just under low
    send_search(VAL_MIN, 0, -1);
    send_search(7, 5, 4);
    send_search(VAL_MAX, LAST_ENTRY, LAST_ENTRY - 1);
    // single entry range at the top of the store, hit and miss
    send_search(VAL_MAX, LAST_ENTRY, LAST_ENTRY);
    send_search(0, LAST_ENTRY, LAST_ENTRY);

    // fill the whole store ascending across the signed range
    prev = VAL_MIN;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      base = longint'(VAL_MIN) + longint'(i) * (longint'(1) << 22);
      v = base + longint'($urandom_range((1 << 22) - 1));
      if (i > 0 && $urandom_range(9) == 0) v = longint'(prev);
      prev = v[OPERAND_W-1:0];
      send_load(i, prev);
    end

    // receiver holds off while searches keep coming, so the input stalls
    holdoff_left = HOLDOFF_LEN;
    repeat (40) random_search();
    wait_drained();

    send_idle_pct  = 82;
    recv_stall_pct = 0;
    random_phase(250);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 82;
    random_phase(250);
    wait_drained();

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    random_phase(250);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("sorted_array_binary_search_core verification clean");
    else
      $display("sorted_array_binary_search_core verification failed");
    $finish;
  end

endmodule
